// File: hw/rtl/eshtb_pkg.sv
// Shared types and constants for the ELF hash table builder.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package eshtb_pkg;

  localparam int DEF_MAX_BUCKETS = 1024;
  localparam int DEF_MAX_SYMBOLS = 1024;

  localparam int CNT_W  = 11;  // bucket_count, symbol_count, symbol numbers, table words
  localparam int HASH_W = 28;
  localparam int BIDX_W = 10;
  localparam int ADDR_W = 12;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_SYMBOL_COUNT = 1'b1;

  typedef struct packed {
    logic name_acc;   // name byte transfer
    logic read_acc;   // read transfer
    logic clear_acc;  // clear transfer
    logic clr_step;   // one entry of the clearing sweep
    logic div_step;   // one bit of the remainder
    logic bkt_rd;     // read the selected bucket
    logic bkt_chk;    // inspect bucket head
    logic chn_rd;     // read chain entry of the current node
    logic chn_chk;    // inspect chain link
    logic rd_issue;   // decode table address, read both stores
    logic load_name;  // load name result into the output register
    logic load_read;  // load table word into the output register
  } eshtb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic fail;
    logic bkt_zero;
    logic chn_zero;
    logic node_big;
    logic step_over;
    logic out_free;
  } eshtb_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/elf_symbol_hash_table_builder.sv
// ELF System V hash table builder: a name byte is taken as one transfer; the last byte of a
// name is followed by a bit-serial remainder (one remainder bit per cycle), a read and check
// of the bucket head, a read and check per chain node walked, and a load of the result;
// an invalid symbol skips the bucket and chain. A table read runs through the transfer,
// address decode with registered store read, and output load. Reset and a
// clear item run a clearing sweep over max(MAX_BUCKETS, MAX_SYMBOLS+1) entries, 1025 at
// the defaults, during which no item is accepted. Results sit in an output register,
// so the next item is taken while a result waits. Depends on eshtb_pkg,
// eshtb_ctrl and eshtb_datapath.
`default_nettype none

module elf_symbol_hash_table_builder
  import eshtb_pkg::*;
#(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [7:0] name_byte, [18:8] symbol_number, [30:19] table_address, [31] zero
  input  wire logic [31:0]       in_tdata,
  // [1:0] kind
  input  wire logic [1:0]        in_tuser,
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [10:0] table_word, [38:11] hash_value, [48:39] bucket_index, [49] status,
  // [55:50] zero
  output logic [55:0]            out_tdata
);

  logic [CNT_W-1:0] bucket_count_r, symbol_count_r;
  logic [CNT_W-1:0] nb, ns;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= CNT_W'(1);
      symbol_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        CFG_SYMBOL_COUNT: symbol_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero buckets act as one; counts saturate at MAX_BUCKETS and MAX_SYMBOLS
  always_comb begin
    if (bucket_count_r == '0)                  nb = CNT_W'(1);
    else if (32'(bucket_count_r) > MAX_BUCKETS) nb = CNT_W'(MAX_BUCKETS);
    else                                       nb = bucket_count_r;
    if (32'(symbol_count_r) > MAX_SYMBOLS)     ns = CNT_W'(MAX_SYMBOLS);
    else                                       ns = symbol_count_r;
  end

  eshtb_cmd_t cmd;
  eshtb_sts_t sts;

  logic [CNT_W-1:0]  o_word;
  logic [HASH_W-1:0] o_hash;
  logic [BIDX_W-1:0] o_bidx;
  logic              o_status;

  eshtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eshtb_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .nb         (nb),
    .ns         (ns),
    .in_byte    (in_tdata[7:0]),
    .in_last    (in_tlast),
    .in_sym     (in_tdata[18:8]),
    .in_addr    (in_tdata[30:19]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_word   (o_word),
    .out_hash   (o_hash),
    .out_bidx   (o_bidx),
    .out_status (o_status)
  );

  assign out_tdata = {6'b0, o_status, o_bidx, o_hash, o_word};

endmodule

`default_nettype wire

// File: hw/rtl/eshtb_ctrl.sv
// Sequencing state machine of the ELF hash table builder.
// Depends on eshtb_pkg; drives the datapath through eshtb_cmd_t.
`default_nettype none

module eshtb_ctrl
  import eshtb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_tuser,
  input  wire logic       in_tlast,
  output logic            in_tready,
  input  wire eshtb_sts_t sts,
  output eshtb_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_DIV    = 10'b00_0000_0100,
    S_BRD    = 10'b00_0000_1000,
    S_BCHK   = 10'b00_0001_0000,
    S_CRD    = 10'b00_0010_0000,
    S_CCHK   = 10'b00_0100_0000,
    S_NOUT   = 10'b00_1000_0000,
    S_RISSUE = 10'b01_0000_0000,
    S_ROUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   xfer;

  assign in_tready = (state_r == S_IDLE);
  assign xfer      = in_tready && in_tvalid;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (xfer) begin
          case (in_tuser)
            KIND_NAME: begin
              cmd.name_acc = 1'b1;
              if (in_tlast) state_nxt = S_DIV;
            end
            KIND_READ: begin
              cmd.read_acc = 1'b1;
              state_nxt    = S_RISSUE;
            end
            KIND_CLEAR: begin
              cmd.clear_acc = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = sts.fail ? S_NOUT : S_BRD;
      end
      S_BRD: begin
        cmd.bkt_rd = 1'b1;
        state_nxt  = S_BCHK;
      end
      S_BCHK: begin
        cmd.bkt_chk = 1'b1;
        state_nxt   = sts.bkt_zero ? S_NOUT : S_CRD;
      end
      S_CRD: begin
        cmd.chn_rd = 1'b1;
        state_nxt  = sts.node_big ? S_NOUT : S_CCHK;
      end
      S_CCHK: begin
        cmd.chn_chk = 1'b1;
        state_nxt   = (sts.chn_zero || sts.step_over) ? S_NOUT : S_CRD;
      end
      S_NOUT: begin
        if (sts.out_free) begin
          cmd.load_name = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_ROUT;
      end
      S_ROUT: begin
        if (sts.out_free) begin
          cmd.load_read = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // reset starts with a clearing sweep of both stores
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/eshtb_datapath.sv
// Datapath of the ELF hash table builder: running hash, bit-serial remainder,
// bucket and chain stores, table read decode and the output register. Uses eshtb_pkg.
`default_nettype none

module eshtb_datapath
  import eshtb_pkg::*;
#(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire eshtb_cmd_t        cmd,
  output eshtb_sts_t             sts,
  input  wire logic [CNT_W-1:0]  nb,
  input  wire logic [CNT_W-1:0]  ns,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic [CNT_W-1:0]  in_sym,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [CNT_W-1:0]       out_word,
  output logic [HASH_W-1:0]      out_hash,
  output logic [BIDX_W-1:0]      out_bidx,
  output logic                   out_status
);

  localparam int CDEPTH = MAX_SYMBOLS + 1;
  localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW     = $clog2(CDEPTH);
  localparam int CLR_N  = (MAX_BUCKETS > CDEPTH) ? MAX_BUCKETS : CDEPTH;
  localparam int CLRW   = $clog2(CLR_N);
  localparam int SW     = $clog2(MAX_SYMBOLS + 2);
  localparam int DCW    = $clog2(HASH_W);

  typedef enum logic [2:0] {
    W_NB, W_NS, W_BKT, W_CHN, W_ZERO
  } wsel_t;

  logic [CNT_W-1:0] bkt_mem [MAX_BUCKETS];
  logic [CNT_W-1:0] chn_mem [CDEPTH];

  logic [HASH_W-1:0] hash_r, res_hash_r;
  logic [CNT_W-1:0]  sym_r, rem_r, node_r;
  logic [DCW-1:0]    cnt_r;
  logic              fail_r;
  logic [SW-1:0]     steps_r;
  logic [CLRW-1:0]   clr_r;
  logic [ADDR_W-1:0] addr_r;
  wsel_t             sel_r;
  logic [CNT_W-1:0]  bkt_rd_r, chn_rd_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_word_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [BIDX_W-1:0] out_bidx_r;
  logic              out_status_r;

  // running hash update
  logic [31:0]       h32;
  logic [HASH_W-1:0] h_new;
  assign h32   = {hash_r, 4'b0} + {24'b0, in_byte};
  assign h_new = h32[HASH_W-1:0] ^ {20'b0, h32[31:28], 4'b0};

  logic sym_bad;
  assign sym_bad = (in_sym == '0) || (in_sym > ns);

  // one restoring step of hash % nb
  logic [CNT_W:0] trial;
  logic [CNT_W:0] nb_ext;
  assign trial  = {rem_r, res_hash_r[cnt_r]};
  assign nb_ext = {1'b0, nb};

  // table address decode
  logic [ADDR_W-1:0] a2, a3;
  assign a2 = addr_r - ADDR_W'(2);
  assign a3 = a2 - {1'b0, nb};

  logic node_big;
  assign node_big = 32'(node_r) > MAX_SYMBOLS;

  logic clearing;
  assign clearing = cmd.clr_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      clr_r  <= '0;
    end else begin
      if (cmd.name_acc) hash_r <= in_last ? '0 : h_new;
      if (cmd.clear_acc) begin
        hash_r <= '0;
        clr_r  <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + CLRW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.name_acc && in_last) begin
      res_hash_r <= h_new;
      sym_r      <= in_sym;
      fail_r     <= sym_bad;
      rem_r      <= '0;
      cnt_r      <= DCW'(HASH_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= (trial >= nb_ext) ? CNT_W'(trial - nb_ext) : CNT_W'(trial);
      cnt_r <= cnt_r - DCW'(1);
    end
    if (cmd.bkt_chk) begin
      node_r  <= bkt_rd_r;
      steps_r <= '0;
    end
    if (cmd.chn_rd && node_big) fail_r <= 1'b1;
    if (cmd.chn_chk && chn_rd_r != '0) begin
      if (32'(steps_r) >= MAX_SYMBOLS + 1) begin
        fail_r <= 1'b1;
      end else begin
        node_r  <= chn_rd_r;
        steps_r <= steps_r + SW'(1);
      end
    end
    if (cmd.read_acc) addr_r <= in_addr;
    if (cmd.rd_issue) begin
      if (addr_r == ADDR_W'(0))          sel_r <= W_NB;
      else if (addr_r == ADDR_W'(1))     sel_r <= W_NS;
      else if (a2 < {1'b0, nb})          sel_r <= W_BKT;
      else if (a3 <= {1'b0, ns})         sel_r <= W_CHN;
      else                               sel_r <= W_ZERO;
    end
  end

  // bucket store: one write and one registered read port
  logic           bkt_we, bkt_re;
  logic [BW-1:0]  bkt_wa, bkt_ra;
  logic [CNT_W-1:0] bkt_wd;
  always_comb begin
    bkt_we = 1'b0;
    bkt_wa = BW'(rem_r);
    bkt_wd = sym_r;
    if (clearing) begin
      bkt_we = 32'(clr_r) < MAX_BUCKETS;
      bkt_wa = BW'(clr_r);
      bkt_wd = '0;
    end else if (cmd.bkt_chk && bkt_rd_r == '0) begin
      bkt_we = 1'b1;
    end
    bkt_re = cmd.bkt_rd || cmd.rd_issue;
    bkt_ra = cmd.rd_issue ? BW'(a2) : BW'(rem_r);
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (bkt_re) bkt_rd_r <= bkt_mem[bkt_ra];
  end

  // chain store
  logic           chn_we, chn_re;
  logic [CW-1:0]  chn_wa, chn_ra;
  logic [CNT_W-1:0] chn_wd;
  always_comb begin
    chn_we = 1'b0;
    chn_wa = CW'(node_r);
    chn_wd = sym_r;
    if (clearing) begin
      chn_we = 32'(clr_r) < CDEPTH;
      chn_wa = CW'(clr_r);
      chn_wd = '0;
    end else if (cmd.chn_chk && chn_rd_r == '0) begin
      chn_we = 1'b1;
    end
    chn_re = (cmd.chn_rd && !node_big) || cmd.rd_issue;
    chn_ra = cmd.rd_issue ? CW'(a3) : CW'(node_r);
  end

  always_ff @(posedge clk) begin
    if (chn_we) chn_mem[chn_wa] <= chn_wd;
    if (chn_re) chn_rd_r <= chn_mem[chn_ra];
  end

  // output register
  logic [CNT_W-1:0] word_sel;
  always_comb begin
    case (sel_r)
      W_NB:    word_sel = nb;
      W_NS:    word_sel = ns + CNT_W'(1);
      W_BKT:   word_sel = bkt_rd_r;
      W_CHN:   word_sel = chn_rd_r;
      default: word_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_name || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_name) begin
      out_word_r   <= '0;
      out_hash_r   <= res_hash_r;
      out_bidx_r   <= BIDX_W'(rem_r);
      out_status_r <= fail_r;
    end else if (cmd.load_read) begin
      out_word_r   <= word_sel;
      out_hash_r   <= '0;
      out_bidx_r   <= '0;
      out_status_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_word   = out_word_r;
  assign out_hash   = out_hash_r;
  assign out_bidx   = out_bidx_r;
  assign out_status = out_status_r;

  always_comb begin
    sts.clr_last  = 32'(clr_r) == CLR_N - 1;
    sts.div_last  = cnt_r == '0;
    sts.fail      = fail_r;
    sts.bkt_zero  = bkt_rd_r == '0;
    sts.chn_zero  = chn_rd_r == '0;
    sts.node_big  = node_big;
    sts.step_over = 32'(steps_r) >= MAX_SYMBOLS + 1;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

`default_nettype wire
